@@ rtl/core/alternate_block_reverser_macros.svh @@
// Assertion macros for the alternate block reverser.
// Uses the module's clock i_clk; ABR_ASSERT also uses its active-low reset i_rst_n.
`ifndef ALTERNATE_BLOCK_REVERSER_MACROS_SVH
`define ALTERNATE_BLOCK_REVERSER_MACROS_SVH

`ifndef ASSERT_OFF

`define ABR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define ABR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define ABR_ASSERT(lbl, prop, msg)

`define ABR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/core/abr_pkg.sv @@
package abr_pkg;

    localparam int MAX_GROUP = 16;
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int IDX_W     = $clog2(MAX_GROUP);
    localparam int CFG_W     = 5;
    localparam int ELEM_W    = 32;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CFG_W-1:0] BLOCK_LENGTH_RESET = CFG_W'(2);

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_PASS,
        OP_FLUSH
    } t_op;

    typedef enum logic {
        ST_TAKE,
        ST_DRAIN
    } t_back_state;

    typedef struct packed {
        t_op                      op;
        logic signed [ELEM_W-1:0] element;
        logic                     fin;
    } t_cmd;

endpackage

@@ rtl/core/abr_front.sv @@
module abr_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [abr_pkg::ELEM_W-1:0] i_element,
    input  logic                              i_final_element,
    input  logic                              i_cfg_we,
    input  logic [abr_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output abr_pkg::t_cmd                     o_cmd
);
    import abr_pkg::*;

    logic [CFG_W-1:0] r_block_length;
    logic             r_phase;
    logic             n_phase;
    logic [CNT_W-1:0] r_pass_cnt;
    logic [CNT_W-1:0] n_pass_cnt;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CNT_W-1:0] eff_len;
    logic [CNT_W-1:0] pass_inc;
    logic [CNT_W-1:0] fill_inc;
    logic             accept;

    always_comb begin
        if (r_block_length == '0) begin
            eff_len = CNT_W'(1);
        end else if (int'(r_block_length) > MAX_GROUP) begin
            eff_len = CNT_W'(MAX_GROUP);
        end else begin
            eff_len = CNT_W'(r_block_length);
        end
    end

    assign accept   = i_valid && !i_q_full;
    assign o_stall  = i_q_full;
    assign o_q_push = accept;
    assign pass_inc = r_pass_cnt + CNT_W'(1);
    assign fill_inc = r_fill + CNT_W'(1);

    always_comb begin
        n_phase       = r_phase;
        n_pass_cnt    = r_pass_cnt;
        n_fill        = r_fill;
        o_cmd.element = i_element;
        o_cmd.fin     = i_final_element;
        o_cmd.op      = OP_PUSH;
        if (r_phase) begin
            o_cmd.op = OP_PASS;
            if (i_final_element || pass_inc >= eff_len) begin
                n_phase    = 1'b0;
                n_pass_cnt = '0;
            end else begin
                n_pass_cnt = pass_inc;
            end
        end else begin
            if (i_final_element || fill_inc >= eff_len) begin
                o_cmd.op   = OP_FLUSH;
                n_fill     = '0;
                n_pass_cnt = '0;
                n_phase    = !i_final_element;
            end else begin
                n_fill = fill_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= BLOCK_LENGTH_RESET;
            r_phase        <= 1'b0;
            r_pass_cnt     <= '0;
            r_fill         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_block_length <= i_cfg_data;
            end
            if (accept) begin
                r_phase    <= n_phase;
                r_pass_cnt <= n_pass_cnt;
                r_fill     <= n_fill;
            end
        end
    end

endmodule

@@ rtl/core/abr_queue.sv @@
module abr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  abr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output abr_pkg::t_cmd o_cmd
);
    import abr_pkg::*;

    t_cmd              r_entry [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/abr_back.sv @@
`include "alternate_block_reverser_macros.svh"

module abr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  abr_pkg::t_cmd                     i_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [abr_pkg::ELEM_W-1:0] o_out_element,
    output logic                              o_out_final
);
    import abr_pkg::*;

    t_back_state              r_state;
    t_back_state              n_state;
    logic signed [ELEM_W-1:0] r_store [MAX_GROUP];
    logic [CNT_W-1:0]         r_sp;
    logic [CNT_W-1:0]         n_sp;
    logic                     r_fin;
    logic                     n_fin;
    logic                     r_valid;
    logic signed [ELEM_W-1:0] r_out_element;
    logic                     r_out_final;
    logic                     out_free;
    logic                     store_we;
    logic                     load;
    logic                     load_final;
    logic [IDX_W-1:0]         rd_idx;
    logic                     take_push;

    assign out_free      = !r_valid || !i_stall;
    assign rd_idx        = IDX_W'(r_sp - CNT_W'(1));
    assign o_valid       = r_valid;
    assign o_out_element = r_out_element;
    assign o_out_final   = r_out_final;
    assign take_push     = (r_state == ST_TAKE) && i_q_valid && (i_cmd.op == OP_PUSH);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_TAKE: begin
                if (i_q_valid && i_cmd.op == OP_FLUSH && out_free && r_sp != '0) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free && r_sp == CNT_W'(1)) begin
                    n_state = ST_TAKE;
                end
            end
            default: n_state = ST_TAKE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        store_we   = 1'b0;
        load       = 1'b0;
        load_final = 1'b0;
        n_sp       = r_sp;
        n_fin      = r_fin;
        case (r_state)
            ST_TAKE: begin
                if (i_q_valid) begin
                    case (i_cmd.op)
                        OP_PUSH: begin
                            o_pop    = 1'b1;
                            store_we = 1'b1;
                            n_sp     = r_sp + CNT_W'(1);
                        end
                        OP_PASS: begin
                            if (out_free) begin
                                o_pop      = 1'b1;
                                load       = 1'b1;
                                load_final = i_cmd.fin;
                            end
                        end
                        OP_FLUSH: begin
                            if (out_free) begin
                                o_pop      = 1'b1;
                                load       = 1'b1;
                                load_final = i_cmd.fin && (r_sp == '0);
                                n_fin      = i_cmd.fin;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_final = r_fin && (r_sp == CNT_W'(1));
                    n_sp       = r_sp - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_sp[IDX_W-1:0]] <= i_cmd.element;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_state == ST_DRAIN) begin
                r_out_element <= r_store[rd_idx];
            end else begin
                r_out_element <= i_cmd.element;
            end
            r_out_final <= load_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_TAKE;
            r_sp    <= '0;
            r_fin   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_fin   <= n_fin;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    `ABR_ASSERT(a_drain_not_empty, (r_state == ST_DRAIN) |-> (r_sp != '0), "Draining an empty stack")
    `ABR_ASSERT(a_push_has_room, take_push |-> (r_sp < CNT_W'(MAX_GROUP)), "Push into full stack")
    `ABR_ASSERT(a_drain_emits, (r_state == ST_DRAIN && out_free) |=> o_valid, "Drain gave no word")
    `ABR_ASSERT_ALWAYS(a_reset_clears, (!i_rst_n) |=> (!o_valid && r_sp == '0), "Reset left state")

endmodule

@@ rtl/core/alternate_block_reverser.sv @@
// Reorders a word stream in alternating groups of block_length words: the first group
// leaves reversed, the next passes unchanged, and so on; a short final reversing group
// leaves reversed, and the last output word carries o_out_final. Accepted words are
// classified by a front stage and queued (two entries) to a back engine that owns the
// 16-entry reversal stack and the output register. The back engine handles one queued
// word or one output word per cycle while the output is not stalled: a passed word goes
// out directly, and a reversing group is stacked but for its last word, which leaves
// first, then the stack is emitted in reverse. The front accepts a word every cycle
// while the queue has room. block_length may only be written while the block is idle.
module alternate_block_reverser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [abr_pkg::ELEM_W-1:0] i_element,
    input  logic                              i_final_element,
    input  logic                              i_cfg_we,
    input  logic [abr_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [abr_pkg::ELEM_W-1:0] o_out_element,
    output logic                              o_out_final
);
    import abr_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    abr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_element       (i_element),
        .i_final_element (i_final_element),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_cmd           (front_cmd)
    );

    abr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (queue_cmd)
    );

    abr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (queue_cmd),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_element (o_out_element),
        .o_out_final   (o_out_final)
    );

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import abr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_WORDS = 350;

    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              last;
    } t_out_word;

    class reorder_scoreboard;
        t_out_word         expected_words[$];
        logic [ELEM_W-1:0] group_stack[MAX_GROUP];
        int unsigned       stack_fill;
        int unsigned       passed_count;
        bit                in_pass_group;
        logic [CFG_W-1:0]  length_reg;
        int                errors;

        function new();
            restart();
            length_reg = BLOCK_LENGTH_RESET;
            errors = 0;
        endfunction

        function void restart();
            stack_fill = 0;
            passed_count = 0;
            in_pass_group = 1'b0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_word(logic [ELEM_W-1:0] value, logic last);
            int unsigned group_len;
            group_len = (length_reg == 0) ? 1 :
                        ((length_reg > MAX_GROUP) ? MAX_GROUP : length_reg);
            if (in_pass_group) begin
                expected_words.push_back('{value, last});
                passed_count++;
                if (last) begin
                    restart();
                end else if (passed_count >= group_len) begin
                    in_pass_group = 1'b0;
                    passed_count = 0;
                end
                return;
            end
            if (stack_fill < MAX_GROUP) begin
                group_stack[stack_fill] = value;
                stack_fill++;
            end
            if (last || stack_fill >= group_len) begin
                while (stack_fill > 0) begin
                    stack_fill--;
                    expected_words.push_back('{group_stack[stack_fill],
                                               last && (stack_fill == 0)});
                end
                if (last) begin
                    restart();
                end else begin
                    in_pass_group = 1'b1;
                    passed_count = 0;
                end
            end
        endfunction

        function void check_word(logic [ELEM_W-1:0] value, logic last);
            t_out_word want;
            if (expected_words.size() == 0) begin
                $error("unexpected word: out_element %h out_final %b", value, last);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (value !== want.value) begin
                $error("out_element mismatch: expected %h, actual %h", want.value, value);
                errors++;
            end
            if (last !== want.last) begin
                $error("out_final mismatch: expected %b, actual %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [ELEM_W-1:0] i_element = '0;
    logic                     i_final_element = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_W-1:0]         i_cfg_data = BLOCK_LENGTH_RESET;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [ELEM_W-1:0] o_out_element;
    logic                     o_out_final;

    reorder_scoreboard board = new();

    int cycle_count = 0;
    int burst_left = 0;
    int stall_period = 1;
    int stall_duty = 0;
    int stall_pos = 0;
    int pattern_left = 0;

    alternate_block_reverser uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_element       (i_element),
        .i_final_element (i_final_element),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_element   (o_out_element),
        .o_out_final     (o_out_final)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_word(o_out_element, o_out_final);
        end
        if (pattern_left == 0) begin
            stall_period = $urandom_range(2, 12);
            stall_duty = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period - 1);
            pattern_left = $urandom_range(50, 400);
        end else begin
            pattern_left--;
        end
        stall_pos = (stall_pos + 1) % stall_period;
        i_stall <= (stall_pos < stall_duty);
    end

    task automatic send_word(input logic [ELEM_W-1:0] value, input logic last);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        i_valid <= 1'b1;
        i_element <= value;
        i_final_element <= last;
        do @(posedge i_clk); while (o_stall);
        board.note_word(value, last);
        burst_left--;
    endtask

    task automatic drain_block();
        i_valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] length);
        i_cfg_we <= 1'b1;
        i_cfg_data <= length;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.length_reg = length;
    endtask

    initial begin
        int sent;
        int seq_len;
        int pick;
        logic [CFG_W-1:0] length;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset length of two: a full reversed group carries the end flag.
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b1);
        send_word(32'h0000_0007, 1'b1);

        drain_block();
        write_length(5'd3);
        for (int i = 1; i <= 4; i++) send_word(i, i == 4);
        for (int i = 0; i < 8; i++) send_word(32'h100 + i, i == 7);

        drain_block();
        write_length(5'd0);
        send_word(32'h0000_0011, 1'b0);
        send_word(32'h0000_0012, 1'b1);

        // Shrinking the length while a reversed group is partly stored.
        drain_block();
        write_length(5'd4);
        for (int i = 0; i < 3; i++) send_word(32'h200 + i, 1'b0);
        drain_block();
        write_length(5'd2);
        send_word(32'h0000_0203, 1'b0);
        send_word(32'h0000_0204, 1'b1);

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) length = 5'd0;
            else if (pick == 1) length = 5'd16;
            else if (pick == 2) length = $urandom_range(0, 1) ? 5'd31
                                                               : CFG_W'($urandom_range(17, 30));
            else if (pick <= 5) length = 5'd1;
            else length = CFG_W'($urandom_range(2, 6));
            drain_block();
            write_length(length);
            repeat ($urandom_range(1, 3)) begin
                seq_len = $urandom_range(1, 36);
                pick = ($urandom_range(0, 7) == 0) ? $urandom_range(1, seq_len) : 0;
                for (int i = 0; i < seq_len; i++) begin
                    if (pick != 0 && i == pick - 1) begin
                        drain_block();
                        write_length(CFG_W'($urandom_range(1, 8)));
                    end
                    send_word($urandom(), i == seq_len - 1);
                    sent++;
                end
            end
        end

        drain_block();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
